>>> rtl/sv39ptw_pkg.sv
// Shared types, constants and microcode encodings of the Sv39 page table walker.
package sv39ptw_pkg;

  // Table store geometry.
  localparam int TABLE_PAGES  = 16;
  localparam int PTE_PER_PAGE = 512;
  localparam int IDX_W        = $clog2(PTE_PER_PAGE);
  localparam int PAGE_W       = $clog2(TABLE_PAGES);
  localparam int ADDR_W       = PAGE_W + IDX_W;
  localparam int FREE_W       = $clog2(TABLE_PAGES + 1);

  // Field widths.
  localparam int VA_W     = 38;
  localparam int PA_W     = 56;
  localparam int SIZE_W   = 32;
  localparam int PERM_W   = 8;
  localparam int PPN_W    = 44;
  localparam int PG_SHIFT = 12;
  localparam int VPN_W    = VA_W + 1 - PG_SHIFT;
  localparam int STATUS_W = 3;

  localparam logic [PERM_W-1:0] PTE_V = PERM_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_RANGE     = 3'd2,
    ST_REMAP     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Stored page table entry: PPN and the low flag byte.
  typedef struct packed {
    logic [PPN_W-1:0]  ppn;
    logic [PERM_W-1:0] flags;
  } pte_t;

  // Microcode step addresses.
  typedef enum logic [3:0] {
    S_RCLR  = 4'd0,
    S_IDLE  = 4'd1,
    S_START = 4'd2,
    S_ISSUE = 4'd3,
    S_TEST  = 4'd4,
    S_NODE  = 4'd5,
    S_PCLR  = 4'd6,
    S_LINK  = 4'd7,
    S_LEAF  = 4'd8,
    S_EMIT  = 4'd9
  } step_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_RCLR  = 4'd1,
    OP_LOAD  = 4'd2,
    OP_START = 4'd3,
    OP_READ  = 4'd4,
    OP_NODE  = 4'd5,
    OP_PCLR  = 4'd6,
    OP_LINK  = 4'd7,
    OP_LEAF  = 4'd8,
    OP_EMIT  = 4'd9
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_CNT_MORE  = 3'd2,
    C_NO_ACCEPT = 3'd3,
    C_LEVEL0    = 3'd4,
    C_VALID     = 3'd5,
    C_OUT_BUSY  = 3'd6
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e jump;
    step_e next;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic stop;
    logic cnt_more;
    logic level0;
    logic pte_valid;
  } dp_flags_t;

endpackage

>>> rtl/sv39ptw_ucode_rom.sv
// Microcode program of the walker: one control word per step.
module sv39ptw_ucode_rom import sv39ptw_pkg::*; (
  input  step_e  step_i,
  output uword_t word_o
);

  always_comb begin
    unique case (step_i)
      S_RCLR:  word_o = '{op: OP_RCLR,  cond: C_CNT_MORE,  jump: S_RCLR,  next: S_IDLE};
      S_IDLE:  word_o = '{op: OP_LOAD,  cond: C_NO_ACCEPT, jump: S_IDLE,  next: S_START};
      S_START: word_o = '{op: OP_START, cond: C_NEVER,     jump: S_START, next: S_ISSUE};
      S_ISSUE: word_o = '{op: OP_READ,  cond: C_NEVER,     jump: S_ISSUE, next: S_TEST};
      S_TEST:  word_o = '{op: OP_NOP,   cond: C_LEVEL0,    jump: S_LEAF,  next: S_NODE};
      S_NODE:  word_o = '{op: OP_NODE,  cond: C_VALID,     jump: S_ISSUE, next: S_PCLR};
      S_PCLR:  word_o = '{op: OP_PCLR,  cond: C_CNT_MORE,  jump: S_PCLR,  next: S_LINK};
      S_LINK:  word_o = '{op: OP_LINK,  cond: C_ALWAYS,    jump: S_ISSUE, next: S_ISSUE};
      S_LEAF:  word_o = '{op: OP_LEAF,  cond: C_ALWAYS,    jump: S_START, next: S_START};
      S_EMIT:  word_o = '{op: OP_EMIT,  cond: C_OUT_BUSY,  jump: S_EMIT,  next: S_IDLE};
      default: word_o = '{op: OP_NOP,   cond: C_ALWAYS,    jump: S_IDLE,  next: S_IDLE};
    endcase
  end

endmodule

>>> rtl/sv39ptw_sequencer.sv
// Step counter of the walker with conditional jumps and an early exit to the result step.
module sv39ptw_sequencer import sv39ptw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  uword_t    word_i,
  input  dp_flags_t flags_i,
  input  logic      in_accept_i,
  input  logic      out_busy_i,
  output step_e     step_o
);

  step_e step_q, step_d;
  logic  cond_hit;

  always_comb begin
    unique case (word_i.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_CNT_MORE:  cond_hit = flags_i.cnt_more;
      C_NO_ACCEPT: cond_hit = ~in_accept_i;
      C_LEVEL0:    cond_hit = flags_i.level0;
      C_VALID:     cond_hit = flags_i.pte_valid;
      C_OUT_BUSY:  cond_hit = out_busy_i;
      default:     cond_hit = 1'b0;
    endcase
  end

  // A step that ends the transaction overrides the program's branch.
  always_comb begin
    priority if (flags_i.stop) begin
      step_d = S_EMIT;
    end else if (cond_hit) begin
      step_d = word_i.jump;
    end else begin
      step_d = word_i.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_RCLR;
    end else begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

>>> rtl/sv39ptw_datapath.sv
// Walker datapath: table store, walk registers and the per-operation update logic.
module sv39ptw_datapath import sv39ptw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  op_e               op_i,
  input  logic              in_accept_i,
  input  logic              mode_i,
  input  logic [VA_W-1:0]   virt_addr_i,
  input  logic [PA_W-1:0]   phys_addr_i,
  input  logic [SIZE_W-1:0] map_bytes_i,
  input  logic [PERM_W-1:0] perm_i,
  input  logic              cfg_we_i,
  input  logic [PPN_W-1:0]  cfg_base_i,
  output dp_flags_t         flags_o,
  output status_e           status_o,
  output logic [PA_W-1:0]   page_addr_o
);

  pte_t mem [TABLE_PAGES * PTE_PER_PAGE];

  logic [PPN_W-1:0]  base_q, base_d;
  logic [FREE_W-1:0] next_free_q, next_free_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              mode_q, mode_d;
  logic              zero_q, zero_d;
  logic [VPN_W-1:0]  vpn_q, vpn_d;
  logic [VPN_W-1:0]  vpn_end_q, vpn_end_d;
  logic [PPN_W-1:0]  ppn_q, ppn_d;
  logic [PERM_W-1:0] perm_q, perm_d;
  logic [1:0]        level_q, level_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [PAGE_W-1:0] fresh_q, fresh_d;
  status_e           status_q, status_d;
  logic [PA_W-1:0]   addr_q, addr_d;
  pte_t              rd_q;

  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] waddr;
  pte_t              wdata;
  logic              we;
  logic              re;
  logic              stop;
  logic [PPN_W-1:0]  off;
  logic              off_in;
  logic              full;
  logic [VA_W:0]     va_last;

  always_comb begin
    unique case (level_q)
      2'd2:    idx = vpn_q[3*IDX_W-1:2*IDX_W];
      2'd1:    idx = vpn_q[2*IDX_W-1:IDX_W];
      default: idx = vpn_q[IDX_W-1:0];
    endcase
  end

  assign walk_addr = {page_q, idx};
  assign off       = rd_q.ppn - base_q;
  assign off_in    = off < PPN_W'(TABLE_PAGES);
  assign full      = next_free_q >= FREE_W'(TABLE_PAGES);
  assign va_last   = {1'b0, virt_addr_i} + {(VA_W + 1 - SIZE_W)'(0), map_bytes_i}
                   - (VA_W + 1)'(1);

  always_comb begin
    base_d      = cfg_we_i ? cfg_base_i : base_q;
    next_free_d = next_free_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    zero_d      = zero_q;
    vpn_d       = vpn_q;
    vpn_end_d   = vpn_end_q;
    ppn_d       = ppn_q;
    perm_d      = perm_q;
    level_d     = level_q;
    page_d      = page_q;
    fresh_d     = fresh_q;
    status_d    = status_q;
    addr_d      = addr_q;
    we          = 1'b0;
    waddr       = walk_addr;
    wdata       = '0;
    re          = 1'b0;
    stop        = 1'b0;
    unique case (op_i)
      OP_RCLR: begin
        we    = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + ADDR_W'(1);
      end
      OP_LOAD: begin
        if (in_accept_i) begin
          mode_d    = mode_i;
          zero_d    = mode_i && (map_bytes_i == '0);
          vpn_d     = {1'b0, virt_addr_i[VA_W-1:PG_SHIFT]};
          vpn_end_d = va_last[VA_W:PG_SHIFT];
          ppn_d     = phys_addr_i[PA_W-1:PG_SHIFT];
          perm_d    = perm_i;
          addr_d    = '0;
        end
      end
      OP_START: begin
        level_d = 2'd2;
        page_d  = '0;
        if (zero_q) begin
          stop     = 1'b1;
          status_d = ST_REMAP;
        end else if (vpn_q[VPN_W-1]) begin
          stop     = 1'b1;
          status_d = ST_RANGE;
        end
      end
      OP_READ: begin
        re = 1'b1;
      end
      OP_NODE: begin
        cnt_d = '0;
        if (rd_q.flags[0]) begin
          if (off_in) begin
            page_d  = off[PAGE_W-1:0];
            level_d = level_q - 2'd1;
          end else begin
            stop     = 1'b1;
            status_d = ST_NOT_FOUND;
          end
        end else if (!mode_q) begin
          stop     = 1'b1;
          status_d = ST_NOT_FOUND;
        end else if (full) begin
          stop     = 1'b1;
          status_d = ST_FULL;
        end else begin
          fresh_d     = next_free_q[PAGE_W-1:0];
          next_free_d = next_free_q + FREE_W'(1);
        end
      end
      OP_PCLR: begin
        we    = 1'b1;
        waddr = {fresh_q, cnt_q[IDX_W-1:0]};
        cnt_d = cnt_q + ADDR_W'(1);
      end
      OP_LINK: begin
        we          = 1'b1;
        wdata.ppn   = base_q + PPN_W'(fresh_q);
        wdata.flags = PTE_V;
        page_d      = fresh_q;
        level_d     = level_q - 2'd1;
      end
      OP_LEAF: begin
        if (!mode_q) begin
          stop     = 1'b1;
          status_d = ST_OK;
          addr_d   = {rd_q.ppn, PG_SHIFT'(0)};
        end else if (rd_q.flags[0]) begin
          stop     = 1'b1;
          status_d = ST_REMAP;
        end else begin
          we          = 1'b1;
          wdata.ppn   = ppn_q;
          wdata.flags = perm_q | PTE_V;
          ppn_d       = ppn_q + PPN_W'(1);
          vpn_d       = vpn_q + VPN_W'(1);
          if (vpn_q == vpn_end_q) begin
            stop     = 1'b1;
            status_d = ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_free_q <= FREE_W'(1);
      cnt_q       <= '0;
    end else begin
      base_q      <= base_d;
      next_free_q <= next_free_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    zero_q    <= zero_d;
    vpn_q     <= vpn_d;
    vpn_end_q <= vpn_end_d;
    ppn_q     <= ppn_d;
    perm_q    <= perm_d;
    level_q   <= level_d;
    page_q    <= page_d;
    fresh_q   <= fresh_d;
    status_q  <= status_d;
    addr_q    <= addr_d;
  end

  assign flags_o.stop      = stop;
  assign flags_o.cnt_more  = (op_i == OP_PCLR) ? ~&cnt_q[IDX_W-1:0] : ~&cnt_q;
  assign flags_o.level0    = (level_q == 2'd0);
  assign flags_o.pte_valid = rd_q.flags[0];
  assign status_o          = status_q;
  assign page_addr_o       = addr_q;

endmodule

>>> rtl/sv39_page_table_walker.sv
// Top level of the Sv39 page table walker: sequencer, datapath and result register.
// Lookup: a new transaction is taken only after the previous result has gone to the result register.
// Map: each 4 KiB page is written as one leaf entry, and each table page allocated
// is zeroed by a sweep before it is linked into the walk.
// Reset clears all 8192 entries of the table store before the first input is taken;
// configuration writes are taken at any time, including during that sweep.
module sv39_page_table_walker import sv39ptw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel: root table PPN.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PPN_W-1:0]    table_base_ppn_i,
  // Request channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [VA_W-1:0]     virt_addr_i,
  input  logic [PA_W-1:0]     phys_addr_i,
  input  logic [SIZE_W-1:0]   map_bytes_i,
  input  logic [PERM_W-1:0]   perm_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [PA_W-1:0]     page_addr_o
);

  step_e           step;
  uword_t          word;
  dp_flags_t       flags;
  status_e         dp_status;
  logic [PA_W-1:0] dp_addr;
  logic            in_accept;
  logic            out_busy;
  logic            emit;

  logic            out_valid_q, out_valid_d;
  status_e         out_status_q;
  logic [PA_W-1:0] out_addr_q;

  // The register is a plain flop, so a configuration transaction is never stalled.
  assign cfg_ready_o = 1'b1;

  // Requests are taken only in the idle step, which the program reaches after the
  // reset sweep and after each result has been handed to the output register.
  assign in_ready_o = (word.op == OP_LOAD);
  assign in_accept  = in_valid_i && in_ready_o;

  // The result register frees up in the same cycle its transaction completes,
  // so the emit step only waits while a previous result is actually stalled.
  assign out_busy = out_valid_q && !out_ready_i;
  assign emit     = (word.op == OP_EMIT) && !out_busy;

  sv39ptw_ucode_rom u_rom (
    .step_i (step),
    .word_o (word)
  );

  sv39ptw_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (word),
    .flags_i     (flags),
    .in_accept_i (in_accept),
    .out_busy_i  (out_busy),
    .step_o      (step)
  );

  sv39ptw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (word.op),
    .in_accept_i (in_accept),
    .mode_i      (mode_i),
    .virt_addr_i (virt_addr_i),
    .phys_addr_i (phys_addr_i),
    .map_bytes_i (map_bytes_i),
    .perm_i      (perm_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_base_i  (table_base_ppn_i),
    .flags_o     (flags),
    .status_o    (dp_status),
    .page_addr_o (dp_addr)
  );

  // Result register: loaded by the emit step, cleared when the consumer takes it.
  always_comb begin
    priority if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= dp_status;
      out_addr_q   <= dp_addr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign page_addr_o = out_addr_q;

  // An accepted request always starts a walk in the next cycle.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> step == S_START)
    else $error("accepted request did not start a walk");

  // A new result only appears after the emit step.
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(step == S_EMIT))
    else $error("result appeared outside the emit step");

  // Only a successful lookup carries an address.
  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> page_addr_o == '0)
    else $error("failed request returned a nonzero address");

  // No request is taken while the sequencer is busy with another one.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step != S_IDLE) |-> !in_ready_o)
    else $error("request channel ready outside the idle step");

endmodule
